FILE: rtl/mcb_pkg.sv
// mcb_pkg: types, codes and default sizes for the motion command buffer.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package mcb_pkg;

  localparam int MCB_FIFO_DEPTH   = 8;
  localparam int MCB_PAYLOAD_BITS = 32;

  // Port widths fixed by the field list
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 3;
  localparam int LIMIT_W   = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  // Input opcodes
  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_COMMAND  = 2'd1;
  localparam logic [1:0] OP_FEEDBACK = 2'd2;

  // Move types
  localparam logic [3:0] MT_CANCEL     = 4'd0;
  localparam logic [3:0] MT_PAUSE      = 4'd1;
  localparam logic [3:0] MT_RESUME     = 4'd2;
  localparam logic [3:0] MT_LAST_VALID = 4'd8;

  // Feedback types
  localparam logic [2:0] FB_RECEIVED = 3'd0;
  localparam logic [2:0] FB_EXECUTED = 3'd1;
  localparam logic [2:0] FB_REJECTED = 3'd2;
  localparam logic [2:0] FB_FULL     = 3'd3;
  localparam logic [2:0] FB_NEED     = 3'd4;
  localparam logic [2:0] FB_ERROR    = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_CLIENT_FB = 2'd0;
  localparam logic [1:0] KIND_EXEC_CMD  = 2'd1;
  localparam logic [1:0] KIND_FORWARD   = 2'd2;
  localparam logic [1:0] KIND_EXIT      = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PAUSE  = 2'd1,
    MODE_RESUME = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // One queued result; from_head takes type and payload from the FIFO head
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] fb;
    logic [7:0] data;
    logic [3:0] mt;
    logic       from_head;
  } slot_t;

  localparam slot_t SLOT_NONE = '0;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       eval;
    logic [1:0] idx;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] eval_count;
    logic [1:0] count;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/motion_command_buffer.sv
// motion_command_buffer: top level, joins the sequencer and the datapath.
// Depends on mcb_pkg, mcb_ctrl and mcb_datapath.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+------------------------------
//   s_        | in        | s_tvalid/s_tready  | s_tuser opcode, s_tdata move
//             |           |                    | and executor feedback fields
//   m_        | out       | m_tvalid/m_tready  | m_tuser kind + exit, m_tdata
//             |           |                    | result fields, m_tlast
//   cfg       | in        | cfg_we             | cfg_data buffer limit
//
// An item has zero to three results. The single-issue sequencer takes the
// transfer, evaluates it against the run state, then emits the results in
// order while m_tready is high. The FIFO head read is registered.
// Reset clears the run state and sets the buffer limit to 5; FIFO entries are
// not cleared, as only entries below the fill count are ever read.
// A stalled result holds its payload; no new item is taken until the last
// result of the current one has gone.
`default_nettype none

module motion_command_buffer #(
  parameter int FIFO_DEPTH   = mcb_pkg::MCB_FIFO_DEPTH,
  parameter int PAYLOAD_BITS = mcb_pkg::MCB_PAYLOAD_BITS
) (
  input  wire                            clk,
  input  wire                            rst,
  // input item
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // [3:0] move_type, [35:4] move_payload, [38:36] feedback_type,
  // [46:39] feedback_data, [47] zero
  input  wire  [mcb_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] opcode
  input  wire  [mcb_pkg::S_TUSER_W-1:0]  s_tuser,
  // result items
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // [2:0] out_feedback, [10:3] out_data, [14:11] out_move_type,
  // [46:15] out_move_payload, [47] zero
  output logic [mcb_pkg::M_TDATA_W-1:0]  m_tdata,
  // [1:0] out_kind, [2] exit_move
  output logic [mcb_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                           m_tlast,
  // buffer limit register
  input  wire                            cfg_we,
  input  wire  [mcb_pkg::LIMIT_W-1:0]    cfg_data
);
  import mcb_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer: accept, evaluate, emit
  mcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // run state, move FIFO and the result slots of one item
  mcb_datapath #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

FILE: rtl/mcb_ctrl.sv
// mcb_ctrl: sequencer for the motion command buffer (accept, evaluate, emit).
// Depends on mcb_pkg.
`default_nettype none

module mcb_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output mcb_pkg::ctrl_cmd_t     cmd,
  input  mcb_pkg::ctrl_stat_t    stat
);
  import mcb_pkg::*;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    cmd.capture = 1'b0;
    cmd.eval    = 1'b0;
    cmd.idx     = idx;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        idx_next = 2'd0;
        state_next = (stat.eval_count != 2'd0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (idx == stat.count - 2'd1) begin
            idx_next   = 2'd0;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mcb_datapath.sv
// mcb_datapath: input register, run state, move FIFO and result slots.
// Depends on mcb_pkg; steered by mcb_ctrl.
`default_nettype none

module mcb_datapath #(
  parameter int FIFO_DEPTH   = mcb_pkg::MCB_FIFO_DEPTH,
  parameter int PAYLOAD_BITS = mcb_pkg::MCB_PAYLOAD_BITS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [mcb_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire  [mcb_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic [mcb_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [mcb_pkg::M_TUSER_W-1:0]    m_tuser,
  output logic                             m_tlast,
  input  wire                              cfg_we,
  input  wire  [mcb_pkg::LIMIT_W-1:0]      cfg_data,
  input  mcb_pkg::ctrl_cmd_t               cmd,
  output mcb_pkg::ctrl_stat_t              stat
);
  import mcb_pkg::*;

  localparam int SB = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [AW-1:0] HEAD_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_T   = (AW + 1)'(FIFO_DEPTH);
  localparam logic [LW-1:0] DEPTH_L   = LW'(FIFO_DEPTH);

  // captured input item
  logic [1:0]    in_op;
  logic [3:0]    in_mt;
  logic [SB-1:0] in_pl;
  logic [2:0]    in_ft;
  logic [7:0]    in_fd;

  // run state
  logic [LIMIT_W-1:0] buffer_limit;
  logic [AW-1:0]      fifo_head;
  logic [CW-1:0]      fifo_count;
  mode_t              run_mode;
  logic               first_dispatched;
  logic [7:0]         sent_count;

  // FIFO store: move type over payload
  logic [SB+3:0] fifo_mem [FIFO_DEPTH];
  logic [SB+3:0] rd_entry;

  // results of the current item
  slot_t         slot [3];
  logic [SB-1:0] cmd_pl;
  logic [1:0]    n_res;
  logic          leave;

  // evaluation
  logic [AW-1:0] cur_head, head_next;
  logic [CW-1:0] cur_count, count_next;
  mode_t         cur_mode, mode_next;
  logic          cur_first, first_next;
  logic [7:0]    cur_sent, sent_next, sent_inc;
  logic [LW-1:0] lim, lim_cfg;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          allowed;
  logic          wr_en;
  slot_t         slot_next [3];
  logic [SB-1:0] cmd_pl_next;
  logic [1:0]    k;
  logic          leave_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op <= s_tuser;
      in_mt <= s_tdata[3:0];
      in_pl <= s_tdata[4 +: SB];
      in_ft <= s_tdata[38:36];
      in_fd <= s_tdata[46:39];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit     <= LIMIT_RESET;
      fifo_head        <= '0;
      fifo_count       <= '0;
      run_mode         <= MODE_IDLE;
      first_dispatched <= 1'b0;
      sent_count       <= 8'd0;
      n_res            <= 2'd0;
    end else begin
      if (cfg_we) buffer_limit <= cfg_data;
      if (cmd.eval) begin
        fifo_head        <= head_next;
        fifo_count       <= count_next;
        run_mode         <= mode_next;
        first_dispatched <= first_next;
        sent_count       <= sent_next;
        n_res            <= k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      slot   <= slot_next;
      cmd_pl <= cmd_pl_next;
      leave  <= leave_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && wr_en) fifo_mem[tail] <= {in_mt, in_pl};
    rd_entry <= fifo_mem[fifo_head];
  end

  always_comb begin
    lim_cfg = LW'(buffer_limit);
    lim     = (lim_cfg > DEPTH_L) ? DEPTH_L : lim_cfg;

    if (in_op == OP_START) begin
      cur_head  = '0;
      cur_count = '0;
      cur_mode  = MODE_IDLE;
      cur_first = 1'b0;
      cur_sent  = 8'd0;
    end else begin
      cur_head  = fifo_head;
      cur_count = fifo_count;
      cur_mode  = run_mode;
      cur_first = first_dispatched;
      cur_sent  = sent_count;
    end
    sent_inc = cur_sent + 8'd1;

    tail_sum = (AW + 1)'(cur_head) + (AW + 1)'(cur_count);
    if (tail_sum >= DEPTH_T) tail_sum = tail_sum - DEPTH_T;
    tail = tail_sum[AW-1:0];

    head_next   = fifo_head;
    count_next  = fifo_count;
    mode_next   = run_mode;
    first_next  = first_dispatched;
    sent_next   = sent_count;
    wr_en       = 1'b0;
    slot_next   = '{SLOT_NONE, SLOT_NONE, SLOT_NONE};
    cmd_pl_next = '0;
    k           = 2'd0;
    leave_next  = 1'b0;
    allowed     = 1'b0;

    case (in_op)
      OP_START, OP_COMMAND: begin
        head_next  = cur_head;
        count_next = cur_count;
        mode_next  = cur_mode;
        first_next = cur_first;
        sent_next  = cur_sent;
        if (in_mt > MT_LAST_VALID) begin
          allowed = 1'b0;
        end else begin
          case (cur_mode)
            MODE_CANCEL: allowed = in_mt inside {MT_CANCEL, MT_PAUSE};
            MODE_PAUSE:  allowed = in_mt inside {MT_CANCEL, MT_PAUSE, MT_RESUME};
            default:     allowed = 1'b1;
          endcase
        end
        if (!allowed) begin
          slot_next[0] = '{kind: KIND_CLIENT_FB, fb: FB_REJECTED, data: 8'd0,
                           mt: 4'd0, from_head: 1'b0};
          k          = 2'd1;
          leave_next = (cur_count == '0);
        end else begin
          if (cur_mode == MODE_IDLE && in_mt == MT_PAUSE) mode_next = MODE_PAUSE;
          else if (cur_mode == MODE_PAUSE && in_mt == MT_RESUME) mode_next = MODE_RESUME;
          else if (in_mt == MT_CANCEL) mode_next = MODE_CANCEL;

          if (in_mt inside {MT_PAUSE, MT_RESUME, MT_CANCEL}) begin
            slot_next[0] = '{kind: KIND_CLIENT_FB, fb: FB_RECEIVED, data: 8'd0,
                             mt: 4'd0, from_head: 1'b0};
            slot_next[1] = '{kind: KIND_EXEC_CMD, fb: 3'd0, data: 8'd0,
                             mt: (in_mt == MT_CANCEL) ? MT_PAUSE : in_mt,
                             from_head: 1'b0};
            k = 2'd2;
            if (in_mt == MT_CANCEL) begin
              count_next = '0;
              head_next  = '0;
            end else begin
              cmd_pl_next = in_pl;
            end
          end else if (LW'(cur_count) >= lim) begin
            slot_next[0] = '{kind: KIND_CLIENT_FB, fb: FB_FULL, data: 8'd0,
                             mt: 4'd0, from_head: 1'b0};
            k = 2'd1;
          end else begin
            wr_en      = 1'b1;
            count_next = cur_count + CW'(1);
            sent_next  = sent_inc;
            slot_next[0] = '{kind: KIND_CLIENT_FB, fb: FB_RECEIVED, data: sent_inc,
                             mt: 4'd0, from_head: 1'b0};
            k = 2'd1;
            if (LW'(count_next) < lim) begin
              slot_next[1] = '{kind: KIND_CLIENT_FB, fb: FB_NEED, data: sent_inc,
                               mt: 4'd0, from_head: 1'b0};
              k = 2'd2;
            end
            if (!cur_first) begin
              first_next   = 1'b1;
              slot_next[k] = '{kind: KIND_EXEC_CMD, fb: 3'd0, data: 8'd0,
                               mt: 4'd0, from_head: 1'b1};
              k = k + 2'd1;
            end
          end
        end
      end
      OP_FEEDBACK: begin
        if (in_ft == FB_EXECUTED) begin
          if (run_mode == MODE_CANCEL) begin
            slot_next[0] = '{kind: KIND_EXEC_CMD, fb: 3'd0, data: 8'd0,
                             mt: MT_CANCEL, from_head: 1'b0};
            k          = 2'd1;
            leave_next = 1'b1;
          end else begin
            if (run_mode == MODE_IDLE && fifo_count != '0) begin
              head_next  = (fifo_head == HEAD_LAST) ? '0 : fifo_head + AW'(1);
              count_next = fifo_count - CW'(1);
            end
            if (run_mode == MODE_RESUME) mode_next = MODE_IDLE;
            slot_next[0] = '{kind: KIND_FORWARD, fb: in_ft, data: in_fd,
                             mt: 4'd0, from_head: 1'b0};
            k = 2'd1;
            if (mode_next == MODE_IDLE) begin
              if (count_next == '0) begin
                leave_next = 1'b1;
              end else begin
                slot_next[1] = '{kind: KIND_EXEC_CMD, fb: 3'd0, data: 8'd0,
                                 mt: 4'd0, from_head: 1'b1};
                k = 2'd2;
                if (LW'(count_next) + LW'(1) == lim) begin
                  slot_next[2] = '{kind: KIND_CLIENT_FB, fb: FB_NEED,
                                   data: sent_count, mt: 4'd0, from_head: 1'b0};
                  k = 2'd3;
                end
              end
            end
          end
        end else if (in_ft == FB_ERROR) begin
          slot_next[0] = '{kind: KIND_FORWARD, fb: in_ft, data: in_fd,
                           mt: 4'd0, from_head: 1'b0};
          k          = 2'd1;
          leave_next = 1'b1;
        end else if (in_ft inside {FB_RECEIVED, FB_NEED}) begin
          k = 2'd0;
        end else begin
          leave_next = (fifo_count == '0);
        end
      end
      default: ;
    endcase

    // exit with nothing else to say: one exit-only result
    if (leave_next && k == 2'd0) begin
      slot_next[0] = '{kind: KIND_EXIT, fb: 3'd0, data: 8'd0, mt: 4'd0,
                       from_head: 1'b0};
      k = 2'd1;
    end
  end

  assign stat.eval_count = k;
  assign stat.count      = n_res;

  // output selection
  slot_t         cur_slot;
  logic [31:0]   out_pl;
  logic [3:0]    out_mt;
  logic          is_last;

  always_comb begin
    cur_slot = slot[cmd.idx];
    is_last  = (cmd.idx == n_res - 2'd1);
    if (cur_slot.from_head) begin
      out_mt = rd_entry[SB+3:SB];
      out_pl = 32'(rd_entry[SB-1:0]);
    end else begin
      out_mt = cur_slot.mt;
      out_pl = (cur_slot.kind == KIND_EXEC_CMD) ? 32'(cmd_pl) : 32'd0;
    end
    m_tdata = {1'b0, out_pl, out_mt, cur_slot.data, cur_slot.fb};
    m_tuser = {is_last & leave, cur_slot.kind};
    m_tlast = is_last;
  end

endmodule

`default_nettype wire

FILE: rtl/mcb_checker.sv
// mcb_checker: port-level checks for motion_command_buffer, bound to the top.
// Depends on mcb_pkg.
`default_nettype none

module mcb_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           s_tvalid,
  input wire                           s_tready,
  input wire                           m_tvalid,
  input wire                           m_tready,
  input wire [mcb_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire [mcb_pkg::M_TUSER_W-1:0]  m_tuser,
  input wire                           m_tlast
);
  import mcb_pkg::*;

  // one item at a time: never take input while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // an accepted item is evaluated before the next can be taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // exit flag only on the final result of an item
  a_exit_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("exit flag on a non-final result");

  // exit-only result is always final and flagged
  a_exit_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == KIND_EXIT) |-> (m_tlast && m_tuser[2]))
    else $error("exit-only result without last or exit flag");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind motion_command_buffer mcb_checker u_mcb_checker (.*);

`default_nettype wire

FILE: tb/sv/motion_command_buffer_tb.sv
// Self-checking testbench for motion_command_buffer: stream stimulus, random idling
// on both sides, and a scoreboard class that predicts every result. Depends on mcb_pkg.
`timescale 1ns / 100ps

module motion_command_buffer_tb;
  import mcb_pkg::*;

  // Codes the package does not name
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [3:0] MT_FIRST_MOVE = 4'd3;
  localparam logic [2:0] FB_OTHER      = 3'd7;

  localparam int DRAIN_CYCLES = 6;       // covers the tail of an item after its results, with margin
  localparam int CYCLE_LIMIT  = 200000;  // far beyond a run with every stall at its worst

  // One result as the client or executor would see it
  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  fb;
    logic [7:0]  data;
    logic [3:0]  mt;
    logic [31:0] payload;
    logic        leave;
    logic        last;
  } move_reply_t;

  // Scoreboard: mirrors the run state and queues the replies each transfer causes
  class command_buffer_checker;
    logic [3:0]    slot_mt [MCB_FIFO_DEPTH];
    logic [31:0]   slot_pl [MCB_FIFO_DEPTH];
    logic [2:0]    head;
    logic [3:0]    count;
    mode_t         mode;
    bit            dispatched;
    logic [7:0]    sent;
    logic [3:0]    limit;
    move_reply_t   awaited[$];
    int unsigned   failures;

    function new();
      clear_run();
      limit    = LIMIT_RESET;
      failures = 0;
    endfunction

    function void clear_run();
      head       = '0;
      count      = '0;
      mode       = MODE_IDLE;
      dispatched = 1'b0;
      sent       = '0;
    endfunction

    function void set_limit(logic [3:0] value);
      limit = value;
    endfunction

    // Limits above the storage act as a full store
    function int cap();
      return (limit > MCB_FIFO_DEPTH) ? MCB_FIFO_DEPTH : int'(limit);
    endfunction

    function void push(logic [1:0] kind, logic [2:0] fb, logic [7:0] data,
                       logic [3:0] mt, logic [31:0] pl);
      move_reply_t r;
      r.kind    = kind;
      r.fb      = fb;
      r.data    = data;
      r.mt      = mt;
      r.payload = pl;
      r.leave   = 1'b0;
      r.last    = 1'b0;
      awaited = {awaited, r};
    endfunction

    function void push_head();
      push(KIND_EXEC_CMD, '0, '0, slot_mt[head], slot_pl[head]);
    endfunction

    // Client command; returns 1 when control goes back to the previous state
    function bit run_command(logic [3:0] mt, logic [31:0] pl);
      bit         ok;
      logic [2:0] tail;
      if (mt > MT_LAST_VALID)
        ok = 1'b0;
      else if (mode == MODE_CANCEL)
        ok = (mt == MT_CANCEL || mt == MT_PAUSE);
      else if (mode == MODE_PAUSE)
        ok = (mt == MT_CANCEL || mt == MT_PAUSE || mt == MT_RESUME);
      else
        ok = 1'b1;
      if (!ok) begin
        push(KIND_CLIENT_FB, FB_REJECTED, '0, '0, '0);
        return count == 0;
      end

      if (mode == MODE_IDLE && mt == MT_PAUSE)
        mode = MODE_PAUSE;
      else if (mode == MODE_PAUSE && mt == MT_RESUME)
        mode = MODE_RESUME;
      else if (mt == MT_CANCEL)
        mode = MODE_CANCEL;

      if (mt == MT_PAUSE || mt == MT_RESUME) begin
        push(KIND_CLIENT_FB, FB_RECEIVED, '0, '0, '0);
        push(KIND_EXEC_CMD, '0, '0, mt, pl);
        return 1'b0;
      end
      // cancel flushes the queue and halts the executor with a bare pause
      if (mt == MT_CANCEL) begin
        push(KIND_CLIENT_FB, FB_RECEIVED, '0, '0, '0);
        count = '0;
        head  = '0;
        push(KIND_EXEC_CMD, '0, '0, MT_PAUSE, '0);
        return 1'b0;
      end

      if (int'(count) >= cap()) begin
        push(KIND_CLIENT_FB, FB_FULL, '0, '0, '0);
        return 1'b0;
      end
      tail          = head + count[2:0];
      slot_mt[tail] = mt;
      slot_pl[tail] = pl;
      count         = count + 4'd1;
      sent          = sent + 8'd1;
      push(KIND_CLIENT_FB, FB_RECEIVED, sent, '0, '0);
      if (int'(count) < cap())
        push(KIND_CLIENT_FB, FB_NEED, sent, '0, '0);
      // only the very first move after a start is sent on arrival
      if (!dispatched) begin
        dispatched = 1'b1;
        push_head();
      end
      return 1'b0;
    endfunction

    function void note_transfer(logic [1:0] op, logic [3:0] mt, logic [31:0] pl,
                                logic [2:0] ft, logic [7:0] fd);
      bit leave;
      int n_prior;
      leave   = 1'b0;
      n_prior = awaited.size();
      if (op == OP_START) begin
        clear_run();
        leave = run_command(mt, pl);
      end else if (op == OP_COMMAND) begin
        leave = run_command(mt, pl);
      end else if (op == OP_FEEDBACK) begin
        if (ft == FB_EXECUTED) begin
          if (mode == MODE_CANCEL) begin
            push(KIND_EXEC_CMD, '0, '0, MT_CANCEL, '0);
            leave = 1'b1;
          end else begin
            // pops only while running; a resumed run falls back to idle
            if (mode == MODE_IDLE) begin
              if (count != 0) begin
                head  = head + 3'd1;
                count = count - 4'd1;
              end
            end else if (mode == MODE_RESUME) begin
              mode = MODE_IDLE;
            end
            push(KIND_FORWARD, ft, fd, '0, '0);
            if (mode == MODE_IDLE) begin
              if (count == 0) begin
                leave = 1'b1;
              end else begin
                push_head();
                if (int'(count) + 1 == cap())
                  push(KIND_CLIENT_FB, FB_NEED, sent, '0, '0);
              end
            end
          end
        end else if (ft == FB_ERROR) begin
          push(KIND_FORWARD, ft, fd, '0, '0);
          leave = 1'b1;
        end else if (ft != FB_RECEIVED && ft != FB_NEED) begin
          leave = (count == 0);
        end
      end else begin
        return;
      end

      if (leave && awaited.size() == n_prior)
        push(KIND_EXIT, '0, '0, '0, '0);
      if (awaited.size() > n_prior) begin
        awaited[awaited.size() - 1].leave = leave;
        awaited[awaited.size() - 1].last  = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser,
                               logic tlast);
      move_reply_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h/%0h/%0b",
                 $time, tuser, tdata, tlast);
        failures++;
        return;
      end
      e = awaited.pop_front();
      compare_field("out_kind",         e.kind,    tuser[1:0]);
      compare_field("exit_move",        e.leave,   tuser[2]);
      compare_field("out_feedback",     e.fb,      tdata[2:0]);
      compare_field("out_data",         e.data,    tdata[10:3]);
      compare_field("out_move_type",    e.mt,      tdata[14:11]);
      compare_field("out_move_payload", e.payload, tdata[46:15]);
      compare_field("last",             e.last,    tlast);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [LIMIT_W-1:0]    cfg_data = '0;

  command_buffer_checker sb = new();
  int                    src_gap_max  = 0;
  int                    sink_gap_max = 0;
  int                    cycle_count  = 0;

  motion_command_buffer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drives one input transfer. Entered and left at a falling edge; tvalid stays
  // high into the next item when no gap is drawn, so the next item is offered at once.
  // Handshakes are sampled straight after the rising edge, before the block's
  // registers update.
  task automatic send_item(input logic [1:0] op, input logic [3:0] mt,
                           input logic [31:0] pl, input logic [2:0] ft,
                           input logic [7:0] fd);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {1'b0, fd, ft, pl, mt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_transfer(op, mt, pl, ft, fd);
    @(negedge clk);
  endtask

  // Lets every awaited result arrive, then the tail of an item with no result
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [3:0] value);
    settle();
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    sb.set_limit(value);
  endtask

  // Mostly move traffic with executor completions behind it; pause, resume and
  // cancel are sparser, since a cancel holds until the next start. Invalid move
  // types, unused opcodes and the non-executed feedback kinds make up the noise.
  task automatic random_item(output logic [1:0] op);
    int          pick;
    logic [3:0]  mt;
    logic [2:0]  ft;
    pick = $urandom_range(0, 99);
    if (pick < 6)       op = OP_START;
    else if (pick < 50) op = OP_COMMAND;
    else if (pick < 97) op = OP_FEEDBACK;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 70)      mt = MT_FIRST_MOVE + 4'($urandom_range(0, 5));
    else if (pick < 78) mt = MT_PAUSE;
    else if (pick < 86) mt = MT_RESUME;
    else if (pick < 90) mt = MT_CANCEL;
    else                mt = MT_LAST_VALID + 4'($urandom_range(1, 7));
    ft = ($urandom_range(0, 99) < 65) ? FB_EXECUTED : 3'($urandom_range(0, 7));
    send_item(op, mt, $urandom, ft, 8'($urandom_range(0, 255)));
  endtask

  // Result side: a random stall ahead of each transfer, with stretches of none
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      if (taken % 16 == 0)
        sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      stall = $urandom_range(0, sink_gap_max);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tuser, m_tlast);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [3:0] phase_limit [6];
    int         phase_items [6];
    logic [1:0] op;
    int         n;
    phase_limit = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'($urandom_range(0, 15))};
    phase_items = '{25, 25, 10, 25, 20, 20};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, buffer limit left at its reset value of five
    // first move after start: received, need data, and straight out to the executor
    send_item(OP_START, MT_FIRST_MOVE, 32'hFFFF_FFFF, FB_RECEIVED, 8'h00);
    send_item(OP_COMMAND, MT_LAST_VALID, 32'h0000_0000, FB_RECEIVED, 8'h00);
    // invalid type with moves queued: rejected, no exit
    send_item(OP_COMMAND, MT_LAST_VALID + 4'd1, 32'h1234_5678, FB_OTHER, 8'hFF);
    // completions with the top data bit set and clear; the second empties the queue
    send_item(OP_FEEDBACK, 4'hF, 32'hFFFF_FFFF, FB_EXECUTED, 8'h80);
    send_item(OP_FEEDBACK, 4'h0, 32'h0000_0000, FB_EXECUTED, 8'h7F);
    // received feedback is swallowed; rejected and other with an empty queue exit alone
    send_item(OP_FEEDBACK, MT_PAUSE, 32'h0, FB_RECEIVED, 8'h01);
    send_item(OP_FEEDBACK, MT_PAUSE, 32'h0, FB_REJECTED, 8'h02);
    send_item(OP_FEEDBACK, MT_PAUSE, 32'h0, FB_OTHER, 8'h03);
    send_item(OP_FEEDBACK, MT_RESUME, 32'h0, FB_ERROR, 8'h55);
    send_item(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 3'h7, 8'hFF);
    // pause, a move refused while paused, a held completion, then resume
    send_item(OP_COMMAND, MT_PAUSE, 32'hA5A5_A5A5, FB_RECEIVED, 8'h00);
    send_item(OP_COMMAND, MT_FIRST_MOVE + 4'd1, 32'h0F0F_0F0F, FB_RECEIVED, 8'h00);
    send_item(OP_FEEDBACK, MT_CANCEL, 32'h0, FB_EXECUTED, 8'h11);
    send_item(OP_COMMAND, MT_RESUME, 32'h5A5A_5A5A, FB_RECEIVED, 8'h00);
    send_item(OP_FEEDBACK, MT_CANCEL, 32'h0, FB_EXECUTED, 8'h22);
    // fill to the limit, then one more answers buffer full
    for (int k = 0; k < 6; k++)
      send_item(OP_COMMAND, MT_FIRST_MOVE + 4'((k + 2) % 6), $urandom, FB_NEED, 8'h00);
    // a pop from a full queue asks for more data
    send_item(OP_FEEDBACK, MT_CANCEL, 32'h0, FB_EXECUTED, 8'hC3);
    // cancel flushes; afterwards moves are refused and completions cancel
    send_item(OP_COMMAND, MT_CANCEL, 32'hDEAD_BEEF, FB_RECEIVED, 8'h00);
    send_item(OP_COMMAND, MT_FIRST_MOVE, 32'h0000_0001, FB_RECEIVED, 8'h00);
    send_item(OP_FEEDBACK, MT_CANCEL, 32'h0, FB_EXECUTED, 8'h44);

    // Random part, one phase per buffer limit; each phase opens with a start
    for (int p = 0; p < 6; p++) begin
      write_limit(phase_limit[p]);
      send_item(OP_START, MT_FIRST_MOVE + 4'($urandom_range(0, 5)), $urandom,
                3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      n = 1;
      while (n < phase_items[p]) begin
        if (n % 16 == 0)
          src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
        random_item(op);
        if (op != OP_UNUSED)
          n++;
      end
    end

    settle();
    if (sb.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mcb_pkg.sv
rtl/mcb_ctrl.sv
rtl/mcb_datapath.sv
rtl/motion_command_buffer.sv
rtl/mcb_checker.sv
tb/sv/motion_command_buffer_tb.sv
